// ----- rtl/ssc_pkg.sv -----
// Package with the field widths, status codes and defaults of the stack sequence checker.
`default_nettype none
package ssc_pkg;

  // Field widths of the stream beats and the configuration register.
  localparam int VAL_W    = 11;
  localparam int NEXT_W   = VAL_W + 1;
  localparam int STATUS_W = 2;

  // Default stack capacity and reset value of the sequence length register.
  localparam int DEF_MAX_LENGTH = 1024;
  localparam logic [VAL_W-1:0] SEQ_LEN_RESET = 11'd1024;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BURIED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/stack_sequence_checker.sv -----
// Stack sequence checker: pushes 1, 2, 3 ... until each target is on top, then pops it.
// Each item passes the READ and EVAL states, the PUSH loop when pushes are needed, then RES.
// Throughput: one item at a time; the push loop writes one stack entry per cycle.
// A new beat may be taken while the previous result still waits on the output.
// Reset (rst, synchronous): empty stack, next value 1, failure cleared, length 1024.
// The stack memory itself is not cleared; only entries below the depth are read.
`default_nettype none
module stack_sequence_checker
  import ssc_pkg::*;
#(
  parameter int MAX_LENGTH = DEF_MAX_LENGTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: sequence_length.
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [10:0] target_value, [15:11] zero
  input  wire logic        s_axis_tuser,  // [0] start_flag
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // [10:0] push_count, [12:11] status, [15:13] zero
);

  localparam int ADDR_W  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int DEPTH_W = $clog2(MAX_LENGTH + 1);
  localparam logic [31:0] MAX_LEN32 = 32'(MAX_LENGTH);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_EVAL = 3'd2;
  localparam logic [2:0] ST_PUSH = 3'd3;
  localparam logic [2:0] ST_RES  = 3'd4;

  logic [2:0]          state;
  logic [VAL_W-1:0]    seq_len;
  logic [VAL_W-1:0]    tgt;
  logic [DEPTH_W-1:0]  depth;
  logic [NEXT_W-1:0]   next_value;
  logic                failed;
  logic [VAL_W-1:0]    res_count;
  logic [STATUS_W-1:0] res_status;
  logic [VAL_W-1:0]    out_count;
  logic [STATUS_W-1:0] out_status;

  logic [VAL_W-1:0]    stack_mem [MAX_LENGTH];
  logic [VAL_W-1:0]    rd_data;

  logic                s_accept;
  logic                out_free;
  logic [DEPTH_W-1:0]  depth_m1;
  logic [VAL_W-1:0]    top;
  logic                out_of_range;
  logic [31:0]         depth_after;
  logic [NEXT_W-1:0]   pushes;
  logic                push_write;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = {3'b000, out_status, out_count};

  // Decision terms for the item held in tgt.
  assign depth_m1     = depth - DEPTH_W'(1);
  assign top          = (depth == '0) ? '0 : rd_data;
  assign out_of_range = (tgt == '0) || (tgt > seq_len) || (32'(tgt) > MAX_LEN32);
  assign pushes       = NEXT_W'(tgt) - next_value + NEXT_W'(1);
  assign depth_after  = 32'(depth) + 32'(pushes);
  assign push_write   = (state == ST_PUSH) && (next_value != NEXT_W'(tgt));

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len <= SEQ_LEN_RESET;
    end else if (cfg_we) begin
      seq_len <= cfg_wdata;
    end
  end

  // Stack memory: one write port for pushes, registered read of the top entry.
  always_ff @(posedge clk) begin
    if (push_write) begin
      stack_mem[depth[ADDR_W-1:0]] <= next_value[VAL_W-1:0];
    end
    rd_data <= stack_mem[depth_m1[ADDR_W-1:0]];
  end

  // Sequencer and stack bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      depth      <= '0;
      next_value <= NEXT_W'(1);
      failed     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            if (s_axis_tuser) begin
              depth      <= '0;
              next_value <= NEXT_W'(1);
              failed     <= 1'b0;
            end
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (failed) begin
            state <= ST_RES;
          end else if (out_of_range) begin
            failed <= 1'b1;
            state  <= ST_RES;
          end else if (tgt == top) begin
            depth <= depth_m1;
            state <= ST_RES;
          end else if (tgt < top) begin
            failed <= 1'b1;
            state  <= ST_RES;
          end else if (NEXT_W'(tgt) < next_value) begin
            failed <= 1'b1;
            state  <= ST_RES;
          end else if (depth_after > MAX_LEN32) begin
            failed <= 1'b1;
            state  <= ST_RES;
          end else begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          next_value <= next_value + NEXT_W'(1);
          if (push_write) begin
            depth <= depth + DEPTH_W'(1);
          end else begin
            state <= ST_RES;
          end
        end
        ST_RES: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Target capture and result fields.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      tgt <= s_axis_tdata[VAL_W-1:0];
    end
    if (state == ST_EVAL) begin
      res_count <= '0;
      if (failed) begin
        res_status <= STATUS_BURIED;
      end else if (out_of_range) begin
        res_status <= STATUS_INVALID;
      end else if (tgt == top) begin
        res_status <= STATUS_OK;
      end else if (tgt < top) begin
        res_status <= STATUS_BURIED;
      end else if (NEXT_W'(tgt) < next_value) begin
        res_status <= STATUS_INVALID;
      end else if (depth_after > MAX_LEN32) begin
        res_status <= STATUS_INVALID;
      end else begin
        res_status <= STATUS_OK;
        res_count  <= pushes[VAL_W-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == ST_RES) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RES) && out_free) begin
      out_count  <= res_count;
      out_status <= res_status;
    end
  end

`ifndef SYNTH
  // Every stacked value is below the next value, so the depth stays under it.
  a_depth_below_next: assert property (@(posedge clk) disable iff (rst)
    32'(depth) < 32'(next_value))
    else $error("stack depth not below next value");

  // The stack never grows past its capacity.
  a_depth_cap: assert property (@(posedge clk) disable iff (rst)
    32'(depth) <= MAX_LEN32)
    else $error("stack depth beyond capacity");

  // An accepted beat blocks further beats while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_axis_tready)
    else $error("ready while an item is in progress");

  // A failing result reports no pushes.
  a_fail_no_count: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_status != STATUS_OK)) |-> (out_count == '0))
    else $error("push count on failed result");

  // The push loop only runs while the next value has not passed the target.
  a_push_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH) |-> (next_value <= NEXT_W'(tgt)))
    else $error("push loop ran past the target");
`endif

endmodule
`default_nettype wire

// ----- dv/stack_sequence_checker_chk.sv -----
// Checker that predicts every result beat of the stack sequence checker and compares it.
`timescale 1ns / 100ps
module stack_sequence_checker_chk
  import ssc_pkg::*;
#(
  parameter int MAX_LENGTH = DEF_MAX_LENGTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [10:0] target_value, [15:11] zero
  input  wire logic        s_axis_tuser,   // [0] start_flag
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [15:0] m_axis_tdata,   // [10:0] push_count, [12:11] status, [15:13] zero
  output int               mismatches,
  output int               results_waiting
);

  typedef struct packed {
    logic [VAL_W-1:0]    push_count;
    logic [STATUS_W-1:0] status;
  } pop_result_t;

  // Shadow copy of the stack, the feed counter, the sticky failure and the length register.
  logic [VAL_W-1:0] stack_mem [MAX_LENGTH];
  int               depth;
  int               next_val;
  bit               run_failed;
  logic [VAL_W-1:0] seq_len;

  pop_result_t awaited_results[$];
  pop_result_t seen;
  pop_result_t want;

  // Works out the outcome of one target and advances the shadow stack.
  function automatic pop_result_t stack_pop_result(input logic [VAL_W-1:0] target,
                                                   input logic start);
    pop_result_t         res;
    logic [STATUS_W-1:0] fault;
    int                  limit;
    int                  top_val;
    int                  pushes;
    int                  v;
    res.push_count = '0;
    res.status     = STATUS_OK;
    fault          = STATUS_OK;
    if (start) begin
      depth      = 0;
      next_val   = 1;
      run_failed = 1'b0;
    end
    // A failed run answers every further target as buried and changes nothing.
    if (run_failed) begin
      res.status = STATUS_BURIED;
      return res;
    end
    limit   = (int'(seq_len) > MAX_LENGTH) ? MAX_LENGTH : int'(seq_len);
    top_val = (depth == 0) ? 0 : int'(stack_mem[depth-1]);
    if (target == 0 || int'(target) > limit) begin
      fault = STATUS_INVALID;
    end else if (int'(target) == top_val) begin
      depth--;
    end else if (int'(target) < top_val) begin
      fault = STATUS_BURIED;
    end else if (int'(target) < next_val) begin
      // Already pushed and popped earlier in this run.
      fault = STATUS_INVALID;
    end else begin
      pushes = int'(target) - next_val + 1;
      if (depth + pushes > MAX_LENGTH) begin
        fault = STATUS_INVALID;
      end else begin
        // Everything below the target stays on the stack; the target itself is popped.
        for (v = next_val; v < int'(target); v++) begin
          stack_mem[depth] = VAL_W'(v);
          depth++;
        end
        next_val       = int'(target) + 1;
        res.push_count = VAL_W'(pushes);
      end
    end
    if (fault != STATUS_OK) begin
      run_failed = 1'b1;
      res.status = fault;
    end
    return res;
  endfunction

  // Prediction on every accepted input beat, comparison on every accepted result beat.
  always @(posedge clk) begin
    if (rst) begin
      depth      = 0;
      next_val   = 1;
      run_failed = 1'b0;
      seq_len    = SEQ_LEN_RESET;
      awaited_results.delete();
      results_waiting <= 0;
    end else begin
      if (cfg_we) begin
        seq_len = cfg_wdata;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(stack_pop_result(s_axis_tdata[VAL_W-1:0], s_axis_tuser));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.push_count = m_axis_tdata[VAL_W-1:0];
        seen.status     = m_axis_tdata[VAL_W+STATUS_W-1:VAL_W];
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing expected, push_count %0d status %0d",
                   $time, seen.push_count, seen.status);
        end else begin
          want = awaited_results.pop_front();
          if (seen.push_count !== want.push_count) begin
            mismatches++;
            $display("%0t: push_count mismatch, expected %0d, actual %0d",
                     $time, want.push_count, seen.push_count);
          end
          if (seen.status !== want.status) begin
            mismatches++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, seen.status);
          end
        end
      end
      results_waiting <= awaited_results.size();
    end
  end

endmodule

// ----- dv/stack_sequence_checker_tb.sv -----
// Testbench top: drives target beats and length settings into the stack sequence checker.
`timescale 1ns / 100ps
module stack_sequence_checker_tb;
  import ssc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_BEATS = 120;
  localparam int NUM_PHASES  = 12;

  typedef struct {
    logic [VAL_W-1:0] target;
    logic             start;
  } pop_req_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_we        = 1'b0;
  logic [10:0] cfg_wdata     = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [10:0] target_value, [15:11] zero
  logic        s_axis_tuser  = 1'b0; // [0] start_flag
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [10:0] push_count, [12:11] status, [15:13] zero

  int       mismatches;
  int       results_waiting;
  int       cycle_count = 0;
  int       ready_mode  = 0;
  int       burst_left  = 0;
  pop_req_t run_q[$];

  // Length settings of the random phases, the register extremes among them.
  int phase_len [NUM_PHASES] = '{16, 2, 1024, 5, 0, 64, 1, 2047, 9, 300, 3, 24};

  stack_sequence_checker DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  stack_sequence_checker_chk CHK (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .mismatches      (mismatches),
    .results_waiting (results_waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The result side switches at random among four stall patterns.
  always @(posedge clk) begin
    if (cycle_count % 256 == 0) begin
      ready_mode <= $urandom_range(0, 3);
    end
    case (ready_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= (cycle_count % 4 == 0);
      default: m_axis_tready <= (cycle_count % 32) >= 8;
    endcase
  end

  // Offers one target beat and holds it until it is taken; bursts are usually separated by gaps.
  task automatic send_beat(input logic [VAL_W-1:0] target, input logic start);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(16-VAL_W){1'b0}}, target};
    s_axis_tuser  <= start;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (results_waiting != 0);
  endtask

  // Writes the length register; the block is idle when this is called.
  task automatic write_length(input logic [10:0] len);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Builds a legal pop order of 1..len_eff by playing a random stack, cut after max_items.
  task automatic build_run(input int len_eff, input int max_items);
    int       held[$];
    int       next_push;
    int       room;
    int       n_push;
    int       made;
    pop_req_t item;
    next_push = 1;
    made      = 0;
    while (made < max_items && (held.size() != 0 || next_push <= len_eff)) begin
      if (held.size() == 0 || (next_push <= len_eff && $urandom_range(0, 1) == 1)) begin
        room = len_eff - next_push + 1;
        // Mostly short pushes, now and then a long run up the sequence.
        if ($urandom_range(0, 15) == 0) begin
          n_push = $urandom_range(1, room);
        end else begin
          n_push = $urandom_range(1, (room < 4) ? room : 4);
        end
        repeat (n_push) begin
          held.push_back(next_push);
          next_push++;
        end
      end
      item.target = VAL_W'(held.pop_back());
      item.start  = (made == 0);
      run_q.push_back(item);
      made++;
    end
  endtask

  // Spoils one beat of the run so that the failure paths and the sticky state are reached.
  task automatic corrupt_run(input int len_eff);
    int               idx;
    logic [VAL_W-1:0] keep;
    idx = $urandom_range(0, run_q.size() - 1);
    case ($urandom_range(0, 6))
      0: run_q[idx].target = '0;
      1: run_q[idx].target = VAL_W'($urandom_range(0, 2047));
      2: run_q[idx].target = VAL_W'(len_eff + 1);
      3: begin
        if (idx > 0) begin
          run_q[idx].target = run_q[$urandom_range(0, idx - 1)].target;
        end
      end
      4: run_q[idx].target = VAL_W'($urandom_range(1, len_eff));
      5: begin
        // Swapping neighbours usually leaves the wanted value buried.
        if (idx + 1 < run_q.size()) begin
          keep                   = run_q[idx].target;
          run_q[idx].target      = run_q[idx + 1].target;
          run_q[idx + 1].target  = keep;
        end
      end
      default: run_q[idx].start = 1'b1;
    endcase
  endtask

  // A handful of arbitrary beats.
  task automatic noise_run();
    pop_req_t item;
    repeat ($urandom_range(1, 6)) begin
      item.target = VAL_W'($urandom_range(0, 2047));
      item.start  = 1'($urandom_range(0, 1));
      run_q.push_back(item);
    end
  endtask

  task automatic play_run();
    foreach (run_q[i]) begin
      send_beat(run_q[i].target, run_q[i].start);
    end
    run_q.delete();
  endtask

  initial begin
    int len_eff;
    int max_items;
    int pick;
    int beats_in_phase;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed beats at the reset length: pushes without a start, pops from the top,
    // a repeat, the sticky failure, the deepest push, a buried target, zero and
    // out-of-range targets.
    send_beat(11'd3, 1'b0);
    send_beat(11'd2, 1'b0);
    send_beat(11'd1, 1'b0);
    send_beat(11'd1, 1'b0);
    send_beat(11'd5, 1'b0);
    send_beat(11'd1024, 1'b1);
    send_beat(11'd1023, 1'b0);
    send_beat(11'd1021, 1'b0);
    send_beat(11'd0, 1'b1);
    send_beat(11'd1025, 1'b1);
    send_beat(11'd2047, 1'b1);
    send_beat(11'd2, 1'b1);
    send_beat(11'd4, 1'b0);
    send_beat(11'd3, 1'b0);
    send_beat(11'd1, 1'b0);

    // Shortest length, then a length that rejects every target, then one above capacity.
    drain();
    write_length(11'd1);
    send_beat(11'd1, 1'b1);
    send_beat(11'd1, 1'b0);
    send_beat(11'd2, 1'b1);
    drain();
    write_length(11'd0);
    send_beat(11'd1, 1'b1);
    send_beat(11'd0, 1'b0);
    drain();
    write_length(11'd2047);
    send_beat(11'd1025, 1'b1);
    send_beat(11'd1024, 1'b1);

    // Random phases: mostly legal pop orders, some spoiled, some pure noise.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_length(11'(phase_len[p]));
      len_eff        = (phase_len[p] > DEF_MAX_LENGTH) ? DEF_MAX_LENGTH : phase_len[p];
      beats_in_phase = 0;
      while (beats_in_phase < PHASE_BEATS) begin
        pick = $urandom_range(0, 19);
        if (len_eff == 0 || pick == 0) begin
          noise_run();
        end else begin
          if (len_eff <= 40) begin
            max_items = ($urandom_range(0, 4) == 0) ? $urandom_range(1, len_eff) : len_eff;
          end else begin
            max_items = $urandom_range(5, 40);
          end
          build_run(len_eff, max_items);
          if (pick <= 3) begin
            corrupt_run(len_eff);
          end
        end
        beats_in_phase += run_q.size();
        play_run();
        if ($urandom_range(0, 9) == 0) begin
          drain();
        end
      end
    end

    // Let the last results arrive and give stray beats time to show up.
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && results_waiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ssc_pkg.sv
rtl/stack_sequence_checker.sv
dv/stack_sequence_checker_chk.sv
dv/stack_sequence_checker_tb.sv
